// ===== rtl/core/lmsd_pkg.sv =====
// Package for the multiplexed LCD segment driver.
// Holds the transaction payload types, command codes and the stage control struct.
// No dependencies.
package lmsd_pkg;

    // Command codes carried in the input transaction
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_TOGGLE = 3'd3;
    localparam logic [2:0] CMD_WRITE  = 3'd4;

    // Fixed field widths of the pin-facing payload and the input row fields
    localparam int COM_OUT_W = 4;
    localparam int SEG_OUT_W = 12;
    localparam int ROW_IN_W  = 12;

    // One input transaction
    typedef struct packed {
        logic [2:0]          command;
        logic [1:0]          common_index;
        logic [3:0]          segment_index;
        logic [ROW_IN_W-1:0] row_mask;
        logic [ROW_IN_W-1:0] row_bits;
    } t_lmsd_in;

    // One result transaction: pin drive for one phase
    typedef struct packed {
        logic [COM_OUT_W-1:0] common_enable;
        logic [COM_OUT_W-1:0] common_level;
        logic [SEG_OUT_W-1:0] segment_level;
        logic                 frame_end;
    } t_lmsd_out;

    // Stage control: item leaves the input register / a result is loaded
    typedef struct packed {
        logic fire;
        logic emit;
    } t_lmsd_ctl;

endpackage

// ===== rtl/core/lmsd_input_stage.sv =====
// Input register of the LCD segment driver.
// Depends on lmsd_pkg for the input payload type.
module lmsd_input_stage import lmsd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_lmsd_in i_data,
    input  logic     i_advance,
    output logic     o_item_valid,
    output t_lmsd_in o_item
);

    logic     r_valid;
    t_lmsd_in r_item;

    // Room when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_data;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== rtl/core/lmsd_store.sv =====
// Display store, frame shadow and phase counter of the LCD segment driver.
// Executes one registered command per fire and forms the pin drive for ticks.
// Depends on lmsd_pkg for payload types and command codes.
module lmsd_store import lmsd_pkg::*; #(
    parameter int NUM_COMMONS  = 4,
    parameter int NUM_SEGMENTS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lmsd_ctl i_ctl,
    input  t_lmsd_in  i_item,
    output t_lmsd_out o_result
);

    localparam int NUM_PHASES = 2 * NUM_COMMONS;
    localparam int PH_W       = $clog2(NUM_PHASES);
    localparam int ROW_IDX_W  = (NUM_COMMONS > 1) ? $clog2(NUM_COMMONS) : 1;

    logic [NUM_SEGMENTS-1:0] r_display [NUM_COMMONS];
    logic [NUM_SEGMENTS-1:0] r_shadow  [NUM_COMMONS];
    logic [PH_W-1:0]         r_phase;

    logic [NUM_SEGMENTS-1:0] n_display [NUM_COMMONS];
    logic [NUM_SEGMENTS-1:0] n_shadow  [NUM_COMMONS];
    logic [PH_W-1:0]         n_phase;

    // Command decode
    logic                     is_tick;
    logic                     com_ok;
    logic                     seg_ok;
    logic [ROW_IDX_W+1:0]     com_wide;
    logic [ROW_IDX_W-1:0]     com_idx;
    logic [NUM_SEGMENTS-1:0]  seg_bit;
    logic [NUM_SEGMENTS+11:0] mask_wide;
    logic [NUM_SEGMENTS+11:0] bits_wide;
    logic [NUM_SEGMENTS-1:0]  row_mask;
    logic [NUM_SEGMENTS-1:0]  row_bits;

    assign is_tick   = (i_item.command == CMD_TICK);
    assign com_ok    = (32'(i_item.common_index) < NUM_COMMONS);
    assign seg_ok    = (32'(i_item.segment_index) < NUM_SEGMENTS);
    assign com_wide  = (ROW_IDX_W + 2)'(i_item.common_index);
    assign com_idx   = com_wide[ROW_IDX_W-1:0];
    assign seg_bit   = seg_ok ? (NUM_SEGMENTS'(1) << i_item.segment_index) : '0;
    assign mask_wide = (NUM_SEGMENTS + 12)'(i_item.row_mask);
    assign bits_wide = (NUM_SEGMENTS + 12)'(i_item.row_bits);
    assign row_mask  = mask_wide[NUM_SEGMENTS-1:0];
    assign row_bits  = bits_wide[NUM_SEGMENTS-1:0];

    // Drive for the current phase
    logic                     up;
    logic                     last;
    logic [PH_W-1:0]          drive_com;
    logic [NUM_SEGMENTS-1:0]  drive_row;
    logic [NUM_SEGMENTS-1:0]  seg_drive;
    logic [NUM_SEGMENTS+11:0] seg_wide;
    logic [COM_OUT_W-1:0]     com_en;

    assign up        = (r_phase < PH_W'(NUM_COMMONS));
    assign last      = (r_phase == PH_W'(NUM_PHASES - 1));
    assign drive_com = up ? r_phase : (r_phase - PH_W'(NUM_COMMONS));
    assign drive_row = r_shadow[drive_com[ROW_IDX_W-1:0]];
    assign seg_drive = up ? ~drive_row : drive_row;
    assign seg_wide  = (NUM_SEGMENTS + 12)'(seg_drive);
    // commons beyond the pin field shift out to zero
    assign com_en    = COM_OUT_W'(1) << drive_com;

    assign o_result.common_enable = com_en;
    assign o_result.common_level  = up ? com_en : '0;
    assign o_result.segment_level = seg_wide[SEG_OUT_W-1:0];
    assign o_result.frame_end     = last;

    // Next state: row edits, phase advance, frame reload
    always_comb begin
        n_phase = r_phase;
        for (int i = 0; i < NUM_COMMONS; i++) begin
            n_display[i] = r_display[i];
            n_shadow[i]  = r_shadow[i];
        end
        if (i_ctl.fire && is_tick) begin
            n_phase = last ? '0 : (r_phase + PH_W'(1));
            if (last) begin
                for (int i = 0; i < NUM_COMMONS; i++) begin
                    n_shadow[i] = r_display[i];
                end
            end
        end
        if (i_ctl.fire && !is_tick && com_ok) begin
            for (int i = 0; i < NUM_COMMONS; i++) begin
                if (com_idx == ROW_IDX_W'(i)) begin
                    case (i_item.command)
                        CMD_SET:    n_display[i] = r_display[i] | seg_bit;
                        CMD_CLEAR:  n_display[i] = r_display[i] & ~seg_bit;
                        CMD_TOGGLE: n_display[i] = r_display[i] ^ seg_bit;
                        CMD_WRITE:  n_display[i] = (r_display[i] & ~row_mask)
                                                 | (row_bits & row_mask);
                        default:    n_display[i] = r_display[i];
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            for (int i = 0; i < NUM_COMMONS; i++) begin
                r_display[i] <= '0;
                r_shadow[i]  <= '0;
            end
        end else begin
            r_phase <= n_phase;
            for (int i = 0; i < NUM_COMMONS; i++) begin
                r_display[i] <= n_display[i];
                r_shadow[i]  <= n_shadow[i];
            end
        end
    end

endmodule

// ===== rtl/core/lmsd_output_stage.sv =====
// Result register of the LCD segment driver.
// Depends on lmsd_pkg for the result payload type.
module lmsd_output_stage import lmsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_lmsd_out i_result,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_lmsd_out o_data
);

    logic      r_valid;
    t_lmsd_out r_data;

    // Free when empty or when the held result is taken this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/lcd_multiplex_segment_driver_unit.sv =====
// Top level of the multiplexed LCD segment driver.
// Depends on lmsd_pkg, lmsd_input_stage, lmsd_store and lmsd_output_stage.
//
// Accepts one transaction per clock. A transaction is captured in an input
// register and executed against the display store and phase counter once it
// leaves that register; a tick's pin drive lands in a result register and is
// offered on the output channel from that register. Row edits give
// no result and never stall. A tick waits in the input register only while
// the result register holds a result that is not being taken, which is what
// sets the rate under output back-pressure. The frame shadow reloads from
// the store on the tick of the last phase, flagged by frame_end.
module lcd_multiplex_segment_driver_unit import lmsd_pkg::*; #(
    parameter int NUM_COMMONS  = 4,
    parameter int NUM_SEGMENTS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_lmsd_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_lmsd_out o_out_data
);

    logic      item_valid;
    t_lmsd_in  item;
    t_lmsd_out result;
    logic      out_free;
    logic      item_is_tick;
    t_lmsd_ctl ctl;

    // Item moves on unless it is a tick facing a full result register
    assign item_is_tick = (item.command == CMD_TICK);
    assign ctl.fire     = item_valid && (!item_is_tick || out_free);
    assign ctl.emit     = ctl.fire && item_is_tick;

    lmsd_input_stage u_input (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_data       (i_in_data),
        .i_advance    (ctl.fire),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    lmsd_store #(
        .NUM_COMMONS  (NUM_COMMONS),
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (item),
        .o_result (result)
    );

    lmsd_output_stage u_output (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (ctl.emit),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

    // A held result is never overwritten by a new tick
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !ctl.emit)
        else $error("tick result loaded over a pending result");

    // Only the driven common may carry a high level
    a_level_in_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.common_level & ~o_out_data.common_enable) == '0))
        else $error("common level high on an undriven common");

    // Frame end falls in the low half of the frame
    a_frame_end_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_end) |-> (o_out_data.common_level == '0))
        else $error("frame end flagged in an up phase");

    // Empty input register always takes a transaction
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !item_valid |-> o_in_ready)
        else $error("input stalled while input register empty");

endmodule
